[rtl/core/safh_pkg.sv]
package safh_pkg;

  localparam int SLOT_W = 10;
  localparam int CNT_W  = SLOT_W + 1;
  localparam int DATA_W = 32;
  localparam int SLOTS  = 1 << SLOT_W;

  localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(SLOTS);

  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic [1:0]        command;
    logic [SLOT_W-1:0] slot;
    logic [DATA_W-1:0] payload;
  } req_t;

  typedef struct packed {
    logic [SLOT_W-1:0] assigned_slot;
    logic [CNT_W-1:0]  used_count;
    logic [DATA_W-1:0] read_data;
    logic [1:0]        status;
  } rsp_t;

  typedef struct packed {
    logic capture;
    logic exec;
  } ctl_cmd_t;

  typedef struct packed {
    logic out_blocked;
  } dp_stat_t;

endpackage

[rtl/core/slot_allocator_fifo_holes_core.sv]
// Slot allocator with a FIFO of freed holes. Each request (add, remove or
// read) passes through a capture step, which reads the hole queue head and
// the addressed entry from their RAMs, and a resolve step, which writes back;
// a new request is taken only once the previous one has been resolved.
// A stalled result register holds the resolve step until it frees up. Both
// RAMs hold garbage after reset; only entries written earlier are ever used.
module slot_allocator_fifo_holes_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  safh_pkg::req_t   in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output safh_pkg::rsp_t   out_data
);
  import safh_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;

  safh_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .stat     (stat),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  safh_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .out_stall (out_stall),
    .stat      (stat),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

[rtl/core/safh_ctrl.sv]
module safh_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  safh_pkg::dp_stat_t  stat,
  output logic                in_stall,
  output safh_pkg::ctl_cmd_t  cmd
);
  import safh_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_r;
  logic state_nxt;

  always_comb begin
    state_nxt   = state_r;
    cmd.capture = 1'b0;
    cmd.exec    = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!stat.out_blocked) begin
          cmd.exec  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_stall = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_exec_after_capture: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |-> $past(cmd.capture) || $past(stat.out_blocked))
    else $error("exec without a captured request");
  a_no_capture_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> !cmd.capture)
    else $error("second capture while busy");
`endif

endmodule

[rtl/core/safh_datapath.sv]
module safh_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  safh_pkg::ctl_cmd_t  cmd,
  input  safh_pkg::req_t      in_data,
  input  logic                out_stall,
  output safh_pkg::dp_stat_t  stat,
  output logic                out_valid,
  output safh_pkg::rsp_t      out_data
);
  import safh_pkg::*;

  logic [SLOT_W-1:0] hole_mem [SLOTS];
  logic [DATA_W-1:0] entry_mem [SLOTS];

  logic [SLOT_W-1:0] head_r, head_nxt;
  logic [SLOT_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0]  level_r, level_nxt;
  logic [CNT_W-1:0]  hw_r, hw_nxt;
  logic              out_valid_r;

  req_t              req_r;
  logic [SLOT_W-1:0] q_hole_r;
  logic [DATA_W-1:0] q_entry_r;
  rsp_t              rsp_r, rsp_nxt;

  logic              ent_we;
  logic [SLOT_W-1:0] ent_addr;
  logic [DATA_W-1:0] ent_wdata;
  logic              hole_we;

  logic [SLOT_W-1:0] sel_slot;
  logic              have;
  logic [CNT_W-1:0]  slot_ext;

  function automatic logic [SLOT_W-1:0] next_pos(input logic [SLOT_W-1:0] p);
    next_pos = (CNT_W'(p) + CNT_W'(1) >= SLOTS_CNT) ? '0 : p + SLOT_W'(1);
  endfunction

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    level_nxt = level_r;
    hw_nxt    = hw_r;
    ent_we    = 1'b0;
    ent_addr  = req_r.slot;
    ent_wdata = '0;
    hole_we   = 1'b0;
    have      = 1'b0;
    sel_slot  = '0;
    slot_ext  = CNT_W'(req_r.slot);
    rsp_nxt   = '0;
    case (req_r.command)
      CMD_ADD: begin
        if (level_r != '0) begin
          sel_slot  = q_hole_r;
          head_nxt  = next_pos(head_r);
          level_nxt = level_r - CNT_W'(1);
          have      = 1'b1;
        end else if (hw_r < SLOTS_CNT) begin
          sel_slot = hw_r[SLOT_W-1:0];
          have     = 1'b1;
        end
        if (have) begin
          ent_we    = 1'b1;
          ent_addr  = sel_slot;
          ent_wdata = req_r.payload;
          if (CNT_W'(sel_slot) == hw_r) begin
            hw_nxt = hw_r + CNT_W'(1);
          end
          rsp_nxt.assigned_slot = sel_slot;
        end else begin
          rsp_nxt.status = ST_FULL;
        end
      end
      CMD_REMOVE: begin
        if (slot_ext >= hw_r) begin
          rsp_nxt.status = ST_RANGE;
        end else if (slot_ext + CNT_W'(1) == hw_r) begin
          hw_nxt = hw_r - CNT_W'(1);
        end else begin
          if (level_r < SLOTS_CNT) begin
            hole_we   = 1'b1;
            tail_nxt  = next_pos(tail_r);
            level_nxt = level_r + CNT_W'(1);
          end
          ent_we = 1'b1;
        end
      end
      CMD_READ: begin
        if (slot_ext >= hw_r) begin
          rsp_nxt.status = ST_RANGE;
        end else begin
          rsp_nxt.read_data = q_entry_r;
        end
      end
      default: rsp_nxt = '0;
    endcase
    rsp_nxt.used_count = hw_nxt;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r     <= in_data;
      q_hole_r  <= hole_mem[head_r];
      q_entry_r <= entry_mem[in_data.slot];
    end
    if (cmd.exec && ent_we) begin
      entry_mem[ent_addr] <= ent_wdata;
    end
    if (cmd.exec && hole_we) begin
      hole_mem[tail_r] <= req_r.slot;
    end
    if (cmd.exec) begin
      rsp_r <= rsp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      level_r     <= '0;
      hw_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.exec) begin
        head_r  <= head_nxt;
        tail_r  <= tail_nxt;
        level_r <= level_nxt;
        hw_r    <= hw_nxt;
      end
      if (cmd.exec) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign stat.out_blocked = out_valid_r && out_stall;
  assign out_valid        = out_valid_r;
  assign out_data         = rsp_r;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    hw_r <= SLOTS_CNT && level_r <= SLOTS_CNT)
    else $error("count or hole level beyond capacity");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |-> !(out_valid_r && out_stall))
    else $error("result overwritten while stalled");
  a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> out_valid_r && out_data.used_count == hw_r)
    else $error("result count does not match state");
  a_queue_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (level_r == '0) |-> head_r == tail_r)
    else $error("empty hole queue with pointers apart");
`endif

endmodule

[tb/slot_checker.sv]
`timescale 1ns / 1ps

module slot_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  safh_pkg::req_t             in_data,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  safh_pkg::rsp_t             out_data,
  output int                         mismatches,
  output int                         pending,
  output logic [safh_pkg::CNT_W-1:0] count_now
);
  import safh_pkg::*;

  logic [SLOT_W-1:0] hole_fifo [SLOTS];
  logic [DATA_W-1:0] slot_entry [SLOTS];
  logic [SLOT_W-1:0] hole_rd;
  logic [SLOT_W-1:0] hole_wr;
  logic [CNT_W-1:0]  hole_cnt;
  logic [CNT_W-1:0]  top_count;
  rsp_t              expected_rsp [$];
  rsp_t              want;
  int                errs = 0;

  function automatic rsp_t resolve_request(req_t r);
    rsp_t              res;
    logic [SLOT_W-1:0] s;
    logic              found;
    res   = '0;
    s     = '0;
    found = 1'b0;
    case (r.command)
      CMD_ADD: begin
        if (hole_cnt != '0) begin
          s        = hole_fifo[hole_rd];
          hole_rd  = hole_rd + SLOT_W'(1);
          hole_cnt = hole_cnt - CNT_W'(1);
          found    = 1'b1;
        end else if (top_count < SLOTS_CNT) begin
          s     = top_count[SLOT_W-1:0];
          found = 1'b1;
        end
        if (found) begin
          slot_entry[s] = r.payload;
          if ({1'b0, s} == top_count) top_count = top_count + CNT_W'(1);
          res.assigned_slot = s;
        end else begin
          res.status = ST_FULL;
        end
      end
      CMD_REMOVE: begin
        if ({1'b0, r.slot} >= top_count) begin
          res.status = ST_RANGE;
        end else if ({1'b0, r.slot} + CNT_W'(1) == top_count) begin
          top_count = top_count - CNT_W'(1);
        end else begin
          // drop the hole when the queue is already full
          if (hole_cnt < SLOTS_CNT) begin
            hole_fifo[hole_wr] = r.slot;
            hole_wr  = hole_wr + SLOT_W'(1);
            hole_cnt = hole_cnt + CNT_W'(1);
          end
          slot_entry[r.slot] = '0;
        end
      end
      CMD_READ: begin
        if ({1'b0, r.slot} >= top_count) res.status = ST_RANGE;
        else res.read_data = slot_entry[r.slot];
      end
      default: ;
    endcase
    res.used_count = top_count;
    return res;
  endfunction

  task automatic flag(string field, logic [DATA_W-1:0] exp_v, logic [DATA_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected 0x%0h, actual 0x%0h", field, exp_v, act_v);
      errs++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      hole_rd   = '0;
      hole_wr   = '0;
      hole_cnt  = '0;
      top_count = '0;
      expected_rsp.delete();
    end else begin
      if (in_valid && !in_stall) expected_rsp = {expected_rsp, resolve_request(in_data)};
      if (out_valid && !out_stall) begin
        if (expected_rsp.size() == 0) begin
          $error("result with no request outstanding: 0x%0h", out_data);
          errs++;
        end else begin
          want = expected_rsp.pop_front();
          flag("assigned_slot", DATA_W'(want.assigned_slot), DATA_W'(out_data.assigned_slot));
          flag("used_count", DATA_W'(want.used_count), DATA_W'(out_data.used_count));
          flag("read_data", want.read_data, out_data.read_data);
          flag("status", DATA_W'(want.status), DATA_W'(out_data.status));
        end
      end
    end
    mismatches <= errs;
    pending    <= expected_rsp.size();
    count_now  <= top_count;
  end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import safh_pkg::*;

  localparam logic [1:0] CMD_NONE    = 2'd3;
  localparam int         CYCLE_LIMIT = 1_000_000;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  req_t             in_data   = '0;
  logic             out_stall = 1'b0;
  logic             calm      = 1'b0;
  logic             in_stall;
  logic             out_valid;
  rsp_t             out_data;
  int               mismatches;
  int               pending;
  logic [CNT_W-1:0] count_now;
  int               stall_left = 0;
  int               cycles     = 0;

  always #10 clk = ~clk;

  slot_allocator_fifo_holes_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  slot_checker u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .mismatches (mismatches),
    .pending    (pending),
    .count_now  (count_now)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  always @(posedge clk) begin
    int r;
    r = $urandom_range(99, 0);
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (calm) begin
      out_stall <= 1'b0;
    end else if (r < 55) begin
      out_stall  <= 1'b0;
      stall_left <= $urandom_range(4, 0);
    end else if (r < 93) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(3, 0);
    end else begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(40, 10);
    end
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(99, 0);
    if (calm || r < 60) return 0;
    if (r < 90) return $urandom_range(3, 1);
    if (r < 98) return $urandom_range(10, 4);
    return $urandom_range(40, 20);
  endfunction

  function automatic req_t mk(logic [1:0] cmd, logic [SLOT_W-1:0] slot,
                              logic [DATA_W-1:0] payload);
    req_t r;
    r.command = cmd;
    r.slot    = slot;
    r.payload = payload;
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] rand_payload();
    int r;
    r = $urandom_range(19, 0);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom();
  endfunction

  function automatic logic [SLOT_W-1:0] aim_slot(int top, int top_share, int below_share);
    int r;
    r = $urandom_range(9, 0);
    if (top == 0) return SLOT_W'($urandom());
    if (r < top_share) return SLOT_W'(top - 1);
    if (r < below_share) return SLOT_W'($urandom_range(top - 1, 0));
    return SLOT_W'($urandom());
  endfunction

  function automatic req_t pick_request();
    int r;
    int top;
    r   = $urandom_range(99, 0);
    top = int'(count_now);
    if (r < 3) return mk(CMD_NONE, SLOT_W'($urandom()), $urandom());
    if (r < 48) return mk(CMD_ADD, SLOT_W'($urandom()), rand_payload());
    if (r < 76) return mk(CMD_REMOVE, aim_slot(top, 3, 8), $urandom());
    return mk(CMD_READ, aim_slot(top, 1, 8), $urandom());
  endfunction

  task automatic send(req_t r);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  initial begin
    int n;
    int top;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // empty store, unknown command, fill a few slots
    send(mk(CMD_READ, 10'd0, 32'h0));
    send(mk(CMD_REMOVE, 10'd0, 32'h0));
    send(mk(CMD_NONE, 10'd1023, 32'hffff_ffff));
    send(mk(CMD_ADD, 10'd1023, 32'h0000_0000));
    send(mk(CMD_ADD, 10'd0, 32'hffff_ffff));
    send(mk(CMD_ADD, 10'd0, 32'ha5a5_a5a5));
    send(mk(CMD_ADD, 10'd0, 32'h5a5a_5a5a));
    send(mk(CMD_READ, 10'd1, 32'h0));
    send(mk(CMD_READ, 10'd4, 32'h0));
    send(mk(CMD_READ, 10'd1023, 32'h0));
    // punch a hole, remove it twice, then shrink below it
    send(mk(CMD_REMOVE, 10'd1, 32'h0));
    send(mk(CMD_READ, 10'd1, 32'h0));
    send(mk(CMD_REMOVE, 10'd3, 32'h0));
    send(mk(CMD_REMOVE, 10'd1, 32'h0));
    send(mk(CMD_REMOVE, 10'd2, 32'h0));
    send(mk(CMD_REMOVE, 10'd1, 32'h0));
    send(mk(CMD_REMOVE, 10'd0, 32'h0));
    // reuse holes left above the count
    send(mk(CMD_ADD, 10'd0, 32'h1234_5678));
    send(mk(CMD_ADD, 10'd0, 32'h8765_4321));
    send(mk(CMD_ADD, 10'd0, 32'hdead_beef));
    send(mk(CMD_ADD, 10'd0, 32'hcafe_f00d));
    send(mk(CMD_READ, 10'd1, 32'h0));
    send(mk(CMD_REMOVE, 10'd1023, 32'h0));
    send(mk(CMD_NONE, 10'd0, 32'h0));
    send(mk(CMD_READ, 10'd0, 32'h0));

    calm <= 1'b1;
    for (n = 0; n < 300; n++) begin
      if (n == 100) calm <= 1'b0;
      send(pick_request());
    end

    // fill the store up to the top, then add past full
    n = 0;
    while (count_now < SLOTS_CNT && n < 3000) begin
      top = int'(count_now);
      if ($urandom_range(9, 0) == 0 && top > 0) send(mk(CMD_READ, aim_slot(top, 1, 10), 32'h0));
      else send(mk(CMD_ADD, SLOT_W'($urandom()), rand_payload()));
      n++;
    end
    repeat (3) send(mk(CMD_ADD, SLOT_W'($urandom()), rand_payload()));

    // queue holes below the top, duplicates included
    for (n = 0; n < 300; n++) begin
      top = int'(count_now);
      if ($urandom_range(11, 0) == 0) send(mk(CMD_READ, SLOT_W'($urandom()), 32'h0));
      else if (top >= 2) send(mk(CMD_REMOVE, SLOT_W'($urandom_range(top - 2, 0)), $urandom()));
      else send(mk(CMD_REMOVE, SLOT_W'($urandom()), $urandom()));
    end

    for (n = 0; n < 150; n++) send(pick_request());

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
